/* rtl/line_tracking_pd_steering_macros.svh */
// ---------------------------------------------------------------------------
// Line tracking PD steering: assertion macros
// Shared concurrent checks, clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINE_TRACKING_PD_STEERING_MACROS_SVH
`define LINE_TRACKING_PD_STEERING_MACROS_SVH

// same-cycle implication
`define LPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lps_pkg.sv */
// ---------------------------------------------------------------------------
// Line tracking PD steering: package
// Types, register map, sequencer states and arithmetic helpers.
// ---------------------------------------------------------------------------
package lps_pkg;

  localparam int MASK_W  = 8;
  localparam int SPEED_W = 16;
  localparam int POS_W   = 12;
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 3;
  localparam int NUM_W   = 12;   // centroid dividend bits
  localparam int DIFF_W  = 13;
  localparam int MA_W    = 16;
  localparam int PROD_W  = MA_W + DIFF_W;
  localparam int ACC_W   = 28;
  localparam int SUM_W   = 34;

  localparam logic [MASK_W-1:0] ALL_BLACK  = 8'hFF;
  localparam logic [MASK_W-1:0] LANE_OUTER = 8'h1F;
  localparam logic [MASK_W-1:0] LANE_INNER = 8'hF8;
  localparam logic [3:0]        LANE_MIN_COUNT = 4'd3;

  localparam logic signed [3:0] SENSOR_WEIGHT [MASK_W] = '{
    -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4
  };

  localparam logic signed [13:0] FAST_POS_THRESHOLD  = 14'sd512;
  localparam logic signed [13:0] FAST_JUMP_THRESHOLD = 14'sd205;
  localparam logic signed [15:0] CURVE_SPEED_FLOOR   = 16'sd12;
  localparam logic [8:0]         WEIGHT_ONE          = 9'd256;
  localparam logic signed [SUM_W-1:0] RND_POS = 34'sd128;
  localparam logic signed [SUM_W-1:0] RND_NEG = 34'sd127;
  localparam logic signed [POS_W-1:0] POS_MAX = 12'sd1024;
  localparam logic signed [POS_W-1:0] POS_MIN = -12'sd1024;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN, REG_DERIV_GAIN, REG_DEAD_ZONE, REG_DRIVE_LIMIT,
    REG_FAST_WEIGHT, REG_SLOW_WEIGHT, REG_CURVE_GAIN, REG_LANE_SELECT
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_FOUND, ST_ALL_BLACK, ST_BRANCH, ST_LOST
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_RAW, S_DIFF, S_FMUL, S_FRND, S_FUPD, S_ERR,
    S_PMUL, S_DMUL, S_DSUM, S_CLAMP, S_CMUL, S_CSUM, S_CSAT,
    S_LSUM, S_LSAT, S_RSAT, S_OUT
  } state_t;

  typedef struct packed {
    logic [14:0] prop_gain;
    logic [14:0] deriv_gain;
    logic [10:0] dead_zone;
    logic [14:0] drive_limit;
    logic [8:0]  fast_weight;
    logic [8:0]  slow_weight;
    logic [14:0] curve_gain;
    logic        lane_select;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    prop_gain:   15'd1792,
    deriv_gain:  15'd8960,
    dead_zone:   11'd154,
    drive_limit: 15'd100,
    fast_weight: 9'd179,
    slow_weight: 9'd64,
    curve_gain:  15'd640,
    lane_select: 1'b0
  };

  typedef struct packed {
    state_t st;
    logic   accept;
    logic   out_load;
    logic   in_ready;
  } ctrl_t;

  typedef struct packed {
    logic found_in;
    logic div_last;
    logic primed;
  } dp_flags_t;

  typedef struct packed {
    status_t                   status;
    logic signed [POS_W-1:0]   pos;
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
  } res_t;

  // divide by 65536 toward zero, saturate to int16
  function automatic logic signed [SPEED_W-1:0] tdiv_sat(input logic signed [SUM_W-1:0] v);
    logic signed [17:0] q;
    q = v[SUM_W-1:16];
    if (v[SUM_W-1] && (v[15:0] != '0)) q = q + 18'sd1;
    if (q > 18'sd32767) return 16'sh7FFF;
    if (q < -18'sd32768) return 16'sh8000;
    return q[SPEED_W-1:0];
  endfunction

  function automatic logic [8:0] weight_sat(input logic [8:0] w);
    return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
  endfunction

endpackage

/* rtl/lps_cfg.sv */
// ---------------------------------------------------------------------------
// Line tracking PD steering: configuration registers
// Indexed register file, written one word at a time, reset to defaults.
// ---------------------------------------------------------------------------
module lps_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [lps_pkg::IDX_W-1:0] wr_idx,
  input  logic [lps_pkg::CFG_W-1:0] wr_data,
  output lps_pkg::cfg_regs_t        regs
);
  import lps_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_PROP_GAIN:   regs_r.prop_gain   <= wr_data;
        REG_DERIV_GAIN:  regs_r.deriv_gain  <= wr_data;
        REG_DEAD_ZONE:   regs_r.dead_zone   <= wr_data[10:0];
        REG_DRIVE_LIMIT: regs_r.drive_limit <= wr_data;
        REG_FAST_WEIGHT: regs_r.fast_weight <= wr_data[8:0];
        REG_SLOW_WEIGHT: regs_r.slow_weight <= wr_data[8:0];
        REG_CURVE_GAIN:  regs_r.curve_gain  <= wr_data;
        REG_LANE_SELECT: regs_r.lane_select <= wr_data[0];
        default: regs_r <= regs_r;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

/* rtl/lps_seq.sv */
// ---------------------------------------------------------------------------
// Line tracking PD steering: sequencer
// Steps the shared datapath through divide, filter, PD and speed stages.
// ---------------------------------------------------------------------------
module lps_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  input  lps_pkg::dp_flags_t  flags,
  output lps_pkg::ctrl_t      ctrl
);
  import lps_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = flags.found_in ? S_DIV : S_OUT;
      S_DIV:   if (flags.div_last) state_nxt = S_RAW;
      S_RAW:   state_nxt = S_DIFF;
      S_DIFF:  state_nxt = flags.primed ? S_FMUL : S_ERR;
      S_FMUL:  state_nxt = S_FRND;
      S_FRND:  state_nxt = S_FUPD;
      S_FUPD:  state_nxt = S_ERR;
      S_ERR:   state_nxt = S_PMUL;
      S_PMUL:  state_nxt = S_DMUL;
      S_DMUL:  state_nxt = S_DSUM;
      S_DSUM:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_CMUL;
      S_CMUL:  state_nxt = S_CSUM;
      S_CSUM:  state_nxt = S_CSAT;
      S_CSAT:  state_nxt = S_LSUM;
      S_LSUM:  state_nxt = S_LSAT;
      S_LSAT:  state_nxt = S_RSAT;
      S_RSAT:  state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.st       = state_r;
    ctrl.in_ready = 1'b0;
    ctrl.accept   = 1'b0;
    ctrl.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.accept   = in_valid;
      end
      S_OUT: begin
        ctrl.out_load = out_free;
      end
      default: begin
        ctrl.in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/lps_dp.sv */
// ---------------------------------------------------------------------------
// Line tracking PD steering: datapath
// Scan classification, radix-2 centroid divider, and one shared multiplier
// and adder for the filter, PD law, curve slowdown and wheel speeds.
// ---------------------------------------------------------------------------
module lps_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lps_pkg::ctrl_t                     ctrl,
  input  logic [lps_pkg::MASK_W-1:0]         in_mask,
  input  logic signed [lps_pkg::SPEED_W-1:0] in_base,
  input  lps_pkg::cfg_regs_t                 cfg,
  output lps_pkg::dp_flags_t                 flags,
  output lps_pkg::res_t                      res
);
  import lps_pkg::*;

  // state
  logic signed [POS_W-1:0]   fpos_r;
  logic                      primed_r;
  logic signed [POS_W-1:0]   prev_r;
  logic [3:0]                divcnt_r;

  // working registers
  status_t                   status_r;
  logic signed [SPEED_W-1:0] base_r;
  logic [NUM_W-1:0]          num_r;
  logic [2:0]                rem_r;
  logic [2:0]                cnt_r;
  logic                      neg_r;
  logic signed [POS_W-1:0]   raw_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [POS_W-1:0]   e_r;
  logic [10:0]               abs_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [31:0]        d_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SPEED_W-1:0] cb_r;
  logic signed [SPEED_W-1:0] left_r;
  logic signed [SPEED_W-1:0] right_r;

  // classification
  logic [3:0]                rc;
  logic [3:0]                cnt;
  logic signed [4:0]         wsum;
  logic [3:0]                awsum;
  logic [MASK_W-1:0]         lane;
  logic [MASK_W-1:0]         mm;
  logic                      all_black;
  status_t                   cls_status;

  always_comb begin
    rc   = '0;
    cnt  = '0;
    wsum = '0;
    for (int i = 0; i < MASK_W; i++) begin
      rc = rc + 4'(in_mask[i]);
    end
    lane = cfg.lane_select ? LANE_INNER : LANE_OUTER;
    mm   = (rc >= LANE_MIN_COUNT) ? (in_mask & lane) : in_mask;
    for (int i = 0; i < MASK_W; i++) begin
      if (mm[i]) begin
        cnt  = cnt + 4'd1;
        wsum = wsum + 5'(SENSOR_WEIGHT[i]);
      end
    end
    awsum     = wsum[4] ? 4'(-wsum) : wsum[3:0];
    all_black = (in_mask == ALL_BLACK);
    if (all_black) begin
      cls_status = ST_ALL_BLACK;
    end else if ((rc >= LANE_MIN_COUNT) && (mm == '0)) begin
      cls_status = ST_BRANCH;
    end else if (cnt == '0) begin
      cls_status = ST_LOST;
    end else begin
      cls_status = ST_FOUND;
    end
  end

  // divider step
  logic [3:0] div_try;
  logic       div_ge;

  assign div_try = {rem_r, num_r[NUM_W-1]};
  assign div_ge  = (div_try >= {1'b0, cnt_r});

  // shared adder
  logic signed [SUM_W-1:0] add_a;
  logic signed [SUM_W-1:0] add_b;
  logic                    add_sub;
  logic signed [SUM_W-1:0] add_y;

  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ctrl.st)
      S_RAW: begin
        add_b   = SUM_W'(num_r);
        add_sub = neg_r;
      end
      S_DIFF: begin
        add_a   = SUM_W'(raw_r);
        add_b   = SUM_W'(fpos_r);
        add_sub = 1'b1;
      end
      S_FRND: begin
        add_a = SUM_W'(prod_r);
        add_b = prod_r[PROD_W-1] ? RND_NEG : RND_POS;
      end
      S_FUPD: begin
        add_a = SUM_W'(fpos_r);
        add_b = sum_r >>> 8;
      end
      S_PMUL: begin
        add_a   = SUM_W'(e_r);
        add_b   = SUM_W'(prev_r);
        add_sub = 1'b1;
      end
      S_DMUL: begin
        add_b   = SUM_W'(fpos_r);
        add_sub = fpos_r[POS_W-1];
      end
      S_DSUM: begin
        add_a = SUM_W'(acc_r);
        add_b = SUM_W'(prod_r);
      end
      S_CSUM: begin
        add_a   = {{2{base_r[SPEED_W-1]}}, base_r, 16'b0};
        add_b   = SUM_W'(prod_r);
        add_sub = 1'b1;
      end
      S_LSUM, S_LSAT: begin
        add_a   = {{2{cb_r[SPEED_W-1]}}, cb_r, 16'b0};
        add_b   = SUM_W'(d_r);
        add_sub = (ctrl.st == S_LSAT);
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_y;
  logic                     fast_sel;

  assign fast_sel = (raw_r >= FAST_POS_THRESHOLD) || (raw_r <= -FAST_POS_THRESHOLD) ||
                    (diff_r >= FAST_JUMP_THRESHOLD) || (diff_r <= -FAST_JUMP_THRESHOLD);
  assign mul_y = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.st)
      S_FMUL: begin
        mul_a = $signed({7'b0, fast_sel ? weight_sat(cfg.fast_weight)
                                        : weight_sat(cfg.slow_weight)});
        mul_b = diff_r;
      end
      S_PMUL: begin
        mul_a = $signed({1'b0, cfg.prop_gain});
        mul_b = DIFF_W'(e_r);
      end
      S_DMUL: begin
        mul_a = $signed({1'b0, cfg.deriv_gain});
        mul_b = diff_r;
      end
      S_CMUL: begin
        mul_a = $signed({1'b0, cfg.curve_gain});
        mul_b = $signed({2'b0, abs_r});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // deadband error
  logic signed [13:0]      p14;
  logic signed [13:0]      dz14;
  logic signed [13:0]      e14;

  always_comb begin
    p14  = 14'(fpos_r);
    dz14 = $signed({3'b0, cfg.dead_zone});
    if (p14 > dz14) begin
      e14 = dz14 - p14;
    end else if (p14 < -dz14) begin
      e14 = -(p14 + dz14);
    end else begin
      e14 = '0;
    end
  end

  // drive clamp and curve floor
  logic signed [31:0]         lim;
  logic signed [SPEED_W-1:0]  neg_dl;
  logic signed [31:0]         nlim;
  logic signed [SPEED_W-1:0]  cb_sat;
  logic signed [SPEED_W-1:0]  min_cb;

  assign lim    = $signed({1'b0, cfg.drive_limit, 16'b0});
  assign neg_dl = 16'sd0 - $signed({1'b0, cfg.drive_limit});
  assign nlim   = {neg_dl, 16'b0};
  assign cb_sat = tdiv_sat(sum_r);
  assign min_cb = (base_r < CURVE_SPEED_FLOOR) ? base_r : CURVE_SPEED_FLOOR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpos_r   <= '0;
      primed_r <= 1'b0;
      prev_r   <= '0;
      divcnt_r <= '0;
    end else begin
      case (ctrl.st)
        S_IDLE: begin
          divcnt_r <= '0;
          if (ctrl.accept && all_black) prev_r <= '0;
        end
        S_DIV: begin
          divcnt_r <= divcnt_r + 4'd1;
        end
        S_DIFF: begin
          if (!primed_r) begin
            fpos_r   <= raw_r;
            primed_r <= 1'b1;
          end
        end
        S_FUPD: begin
          fpos_r <= add_y[POS_W-1:0];
        end
        S_DMUL: begin
          prev_r <= e_r;
        end
        default: begin
          divcnt_r <= divcnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.st)
      S_IDLE: begin
        if (ctrl.accept) begin
          base_r   <= in_base;
          left_r   <= in_base;
          right_r  <= in_base;
          status_r <= cls_status;
          num_r    <= {awsum, 6'b0, cnt[2:1]};
          rem_r    <= '0;
          neg_r    <= wsum[4];
          cnt_r    <= cnt[2:0];
        end
      end
      S_DIV: begin
        rem_r <= div_ge ? 3'(div_try - {1'b0, cnt_r}) : div_try[2:0];
        num_r <= {num_r[NUM_W-2:0], div_ge};
      end
      S_RAW:   raw_r  <= add_y[POS_W-1:0];
      S_DIFF:  diff_r <= add_y[DIFF_W-1:0];
      S_FMUL:  prod_r <= mul_y;
      S_FRND:  sum_r  <= add_y;
      S_ERR:   e_r    <= e14[POS_W-1:0];
      S_PMUL: begin
        acc_r  <= mul_y[ACC_W-1:0];
        diff_r <= add_y[DIFF_W-1:0];
      end
      S_DMUL: begin
        prod_r <= mul_y;
        abs_r  <= add_y[10:0];
      end
      S_DSUM:  acc_r <= add_y[ACC_W-1:0];
      S_CLAMP: begin
        if (acc_r > lim) begin
          d_r <= lim;
        end else if (acc_r < nlim) begin
          d_r <= nlim;
        end else begin
          d_r <= 32'(acc_r);
        end
      end
      S_CMUL:  prod_r <= mul_y;
      S_CSUM:  sum_r  <= add_y;
      S_CSAT:  cb_r   <= (cb_sat < min_cb) ? min_cb : cb_sat;
      S_LSUM:  sum_r  <= add_y;
      S_LSAT: begin
        left_r <= tdiv_sat(sum_r);
        sum_r  <= add_y;
      end
      S_RSAT:  right_r <= tdiv_sat(sum_r);
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign flags.found_in = (cls_status == ST_FOUND);
  assign flags.div_last = (divcnt_r == 4'(NUM_W - 1));
  assign flags.primed   = primed_r;

  assign res.status = status_r;
  assign res.pos    = fpos_r;
  assign res.left   = left_r;
  assign res.right  = right_r;

endmodule

/* rtl/line_tracking_pd_steering.sv */
// ---------------------------------------------------------------------------
// Line tracking PD steering: top level
// Eight-sensor line follower with adaptive position filter and PD steering.
// ---------------------------------------------------------------------------
// A scan is taken only while the sequencer is idle. A scan with a line found
// passes from acceptance through the bit-serial centroid divide and 16 steps
// through the one shared multiplier and adder before its result is loaded into
// the output register. The first found scan after reset loads the filter
// directly and skips the three filter update steps. All-black, branch-ignored
// and line-lost scans go from acceptance straight to the output load. The load
// waits while the output register still holds an unaccepted word. The output
// register holds a finished word while the next scan is accepted. No clearing
// pass after reset; configuration writes are taken every cycle.
`include "line_tracking_pd_steering_macros.svh"

module line_tracking_pd_steering (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // sensor_mask[7:0], speed_cmd[23:8]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,  // line_position[11:0], left_speed[27:12],
                                                // right_speed[43:28], zero[47:44]
  output logic [1:0]                out_tuser,  // status[1:0]
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lps_pkg::IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_W-1:0] cfg_data
);
  import lps_pkg::*;

  cfg_regs_t cfg;
  ctrl_t     ctrl;
  dp_flags_t flags;
  res_t      res;
  logic      out_free;

  logic      out_valid_r;
  res_t      out_res_r;

  assign cfg_ready = 1'b1;

  lps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .regs    (cfg)
  );

  lps_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  lps_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_mask (in_tdata[7:0]),
    .in_base ($signed(in_tdata[23:8])),
    .cfg     (cfg),
    .flags   (flags),
    .res     (res)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_res_r <= res;
    end
  end

  assign in_tready  = ctrl.in_ready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0, out_res_r.right, out_res_r.left, out_res_r.pos};

  `LPS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "scan accepted while previous still in work")
  `LPS_ASSERT_NEXT(a_word_drains, out_tvalid && out_tready && !ctrl.out_load, !out_tvalid,
    "output word repeated")
  `LPS_ASSERT_IMPLY(a_load_free, ctrl.out_load, !out_valid_r || out_tready,
    "output word overwritten")
  `LPS_ASSERT_IMPLY(a_pos_range, out_tvalid,
    ($signed(out_tdata[11:0]) >= POS_MIN) && ($signed(out_tdata[11:0]) <= POS_MAX),
    "line position out of range")

endmodule

/* tb/line_tracking_pd_steering_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Line tracking PD steering: testbench
// Streams sensor scans into the block under several register settings,
// predicts each status, filtered position and wheel speed pair, and checks
// every output word in order against the prediction.
// ---------------------------------------------------------------------------
module line_tracking_pd_steering_tb;
  import lps_pkg::*;

  localparam longint POS_FAST_LIM   = 512;
  localparam longint JUMP_FAST_LIM  = 205;
  localparam longint CURVE_FLOOR    = 12;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     RANDOM_SCANS   = 103;

  typedef struct {
    logic [7:0]         mask;
    logic signed [15:0] speed;
  } scan_t;

  typedef struct {
    status_t            status;
    logic signed [11:0] pos;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } steer_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [23:0]        in_tdata = '0;     // sensor_mask[7:0], speed_cmd[23:8]
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [47:0]        out_tdata;         // line_position[11:0], left_speed[27:12],
                                         // right_speed[43:28], zero[47:44]
  logic [1:0]         out_tuser;         // status[1:0]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // register copies
  longint kp = 1792, kd = 8960, dz_w = 154, lim_w = 100;
  longint wf = 179, ws = 64, ck = 640;
  bit     lane_in = 1'b0;

  // steering state
  longint filt_pos = 0;
  bit     primed = 1'b0;
  longint prev_err = 0;

  scan_t      scan_q[$];
  steer_res_t steer_exp_q[$];

  int fail_cnt = 0;
  int gap_cnt = 0;
  int burst_cnt = 8;
  int idle_cnt = 0;
  int pat_age = 0;
  int walk_pos = 3;
  logic [15:0] stall_pat = '1;

  byte unsigned dir_mask [24] = '{
    8'h00, 8'hE0, 8'hFF, 8'h01, 8'h80, 8'h18, 8'h10, 8'h08,
    8'h0C, 8'h07, 8'h1F, 8'hF8, 8'h3C, 8'h55, 8'hAA, 8'h81,
    8'h7F, 8'hFE, 8'h00, 8'hFF, 8'h02, 8'h04, 8'h20, 8'h40
  };
  shortint dir_speed [24] = '{
    100, 100, -5, 32767, -32768, 0, 12, 11,
    200, 500, 300, 300, -1, 1000, -1000, 50,
    32767, -32768, -32768, 32767, 40, 40, 40, 40
  };

  line_tracking_pd_steering u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint div_round(input longint num, input longint den);
    if (num >= 0)
      return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767)
      return 16'sh7FFF;
    if (v < -32768)
      return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic steer_res_t steer_predict(input logic [7:0] mask_in,
                                               input logic signed [15:0] speed_in);
    steer_res_t r;
    logic [7:0] m;
    int nset, wsum, cnt;
    longint base, rawp, diff, w, pos, err, drv, lim, prod, cb, mincb;
    m = mask_in;
    base = speed_in;
    nset = $countones(mask_in);
    wsum = 0;
    cnt = 0;
    r.status = ST_LOST;
    r.left = speed_in;
    r.right = speed_in;
    if (mask_in == 8'hFF) begin
      prev_err = 0;
      r.status = ST_ALL_BLACK;
    end else begin
      if (nset >= 3)
        m = m & (lane_in ? 8'hF8 : 8'h1F);
      for (int i = 0; i < 8; i++) begin
        if (m[i]) begin
          wsum += (i < 4) ? i - 4 : i - 3;
          cnt++;
        end
      end
      if (nset >= 3 && m == 8'h00) begin
        r.status = ST_BRANCH;
      end else if (cnt != 0) begin
        rawp = div_round(longint'(wsum) * 256, cnt);
        if (!primed) begin
          filt_pos = rawp;
          primed = 1'b1;
        end else begin
          diff = rawp - filt_pos;
          if ((rawp < 0 ? -rawp : rawp) >= POS_FAST_LIM ||
              (diff < 0 ? -diff : diff) >= JUMP_FAST_LIM)
            w = wf;
          else
            w = ws;
          if (w > 256)
            w = 256;
          filt_pos += div_round(w * diff, 256);
        end
        pos = filt_pos;
        if (pos > dz_w)
          err = -(pos - dz_w);
        else if (pos < -dz_w)
          err = -(pos + dz_w);
        else
          err = 0;
        drv = kp * err + kd * (err - prev_err);
        prev_err = err;
        lim = lim_w * 65536;
        if (drv > lim)
          drv = lim;
        else if (drv < -lim)
          drv = -lim;
        prod = base * 65536 - (pos < 0 ? -pos : pos) * ck;
        cb = sat16(prod / 65536);
        mincb = (base < CURVE_FLOOR) ? base : CURVE_FLOOR;
        if (cb < mincb)
          cb = mincb;
        r.left = sat16((cb * 65536 + drv) / 65536);
        r.right = sat16((cb * 65536 - drv) / 65536);
        r.status = ST_FOUND;
      end
    end
    r.pos = filt_pos[11:0];
    return r;
  endfunction

  // mostly line-like runs that wander, plus noise, gaps and crossings
  function automatic logic [7:0] pick_mask();
    int sel, len;
    logic [15:0] run;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      walk_pos = walk_pos + int'($urandom_range(0, 2)) - 1;
      if (walk_pos < 0) walk_pos = 0;
      if (walk_pos > 7) walk_pos = 7;
      len = $urandom_range(1, 3);
      run = ((16'd1 << len) - 16'd1) << walk_pos;
      return run[7:0];
    end
    if (sel < 75)
      return 8'($urandom_range(0, 255));
    if (sel < 82)
      return 8'h00;
    if (sel < 88)
      return 8'hFF;
    len = $urandom_range(3, 5);
    run = ((16'd1 << len) - 16'd1) << $urandom_range(0, 8 - len);
    return run[7:0];
  endfunction

  function automatic logic signed [15:0] pick_speed();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v = 32'hFFFF_8000;
      1: v = 32'h0000_7FFF;
      2: v = 32'd0;
      3: v = 32'hFFFF_FFFF;
      4: v = 32'd12;
      default: v = 32'd11;
    endcase
    if (sel < 8)
      return v[15:0];
    if (sel < 50) begin
      v = $urandom_range(0, 400) - 32'd100;
      return v[15:0];
    end
    v = $urandom;
    return v[15:0];
  endfunction

  task automatic queue_random(input int n);
    repeat (n) scan_q.push_back('{pick_mask(), pick_speed()});
  endtask

  task automatic drain();
    while (scan_q.size() != 0 || in_tvalid || steer_exp_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[14:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   kp = val[14:0];
      REG_DERIV_GAIN:  kd = val[14:0];
      REG_DEAD_ZONE:   dz_w = val[10:0];
      REG_DRIVE_LIMIT: lim_w = val[14:0];
      REG_FAST_WEIGHT: wf = val[8:0];
      REG_SLOW_WEIGHT: ws = val[8:0];
      REG_CURVE_GAIN:  ck = val[14:0];
      REG_LANE_SELECT: lane_in = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int unsigned p, d, z, l, f, s, c, ln);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_DEAD_ZONE, z);
    write_reg(REG_DRIVE_LIMIT, l);
    write_reg(REG_FAST_WEIGHT, f);
    write_reg(REG_SLOW_WEIGHT, s);
    write_reg(REG_CURVE_GAIN, c);
    write_reg(REG_LANE_SELECT, ln);
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  // scan driver: bursts with random gaps
  always @(posedge clk) begin
    scan_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        steer_exp_q.push_back(steer_predict(in_tdata[7:0], in_tdata[23:8]));
      if (!in_tvalid || in_tready) begin
        if (gap_cnt > 0 || scan_q.size() == 0) begin
          if (gap_cnt > 0)
            gap_cnt--;
          in_tvalid <= 1'b0;
        end else begin
          nxt = scan_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.speed, nxt.mask};
          burst_cnt--;
          if (burst_cnt <= 0) begin
            burst_cnt = $urandom_range(1, 30);
            gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end
  end

  // result monitor, ready follows a rotating stall pattern
  always @(posedge clk) begin
    steer_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (steer_exp_q.size() == 0) begin
          $display("%0t ns: unexpected word: expected none, actual %h/%h",
                   $time, out_tuser, out_tdata);
          fail_cnt++;
        end else begin
          want = steer_exp_q.pop_front();
          check_field("status", longint'(want.status), longint'(out_tuser));
          check_field("line_position", longint'(want.pos),
                      longint'($signed(out_tdata[11:0])));
          check_field("left_speed", longint'(want.left),
                      longint'($signed(out_tdata[27:12])));
          check_field("right_speed", longint'(want.right),
                      longint'($signed(out_tdata[43:28])));
        end
      end
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | 32'd1);
        pat_age = 64;
      end
      pat_age--;
      out_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: edge masks, lane cut, all statuses, speed extremes
    foreach (dir_mask[i])
      scan_q.push_back('{dir_mask[i], dir_speed[i]});
    queue_random(RANDOM_SCANS);

    drain();
    set_all(32767, 32767, 1024, 32767, 256, 256, 32767, 1);
    queue_random(RANDOM_SCANS);

    drain();
    set_all(0, 0, 0, 0, 0, 0, 0, 0);
    queue_random(RANDOM_SCANS);

    // all data bits set: weights above one, deadband past full scale
    drain();
    set_all(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF);
    queue_random(RANDOM_SCANS);

    repeat (4) begin
      drain();
      set_all($urandom_range(0, 6000), $urandom_range(0, 32767), $urandom_range(0, 1100),
              $urandom_range(0, 2000), $urandom_range(0, 300), $urandom_range(0, 300),
              $urandom_range(0, 3000), $urandom_range(0, 1));
      queue_random(RANDOM_SCANS);
    end

    drain();
    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_cfg.sv
rtl/lps_seq.sv
rtl/lps_dp.sv
rtl/line_tracking_pd_steering.sv
tb/line_tracking_pd_steering_tb.sv
